### design/rhmf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package rhmf_pkg;

	localparam int MAX_WIDTH  = 1024;
	localparam int MAX_RADIUS = 7;
	localparam int SIDE_MAX   = 2 * MAX_RADIUS + 1;
	localparam int STORE_ROWS = 2 * MAX_RADIUS;
	localparam int LS_DEPTH   = STORE_ROWS * MAX_WIDTH;
	localparam int LS_AW      = $clog2(LS_DEPTH);
	localparam int COL_W      = 10;
	localparam int ROW_W      = 10;
	localparam int CFG_W      = 11;
	localparam int RAD_W      = 3;
	localparam int SIDE_W     = $clog2(SIDE_MAX + 1);
	localparam int PIX_W      = 24;
	localparam int BINS       = 256;
	localparam int BIN_W      = $clog2(BINS);
	localparam int CNT_W      = 8;
	localparam int HALF_W     = 7;
	localparam int APB_AW     = 4;
	localparam int APB_DW     = 32;
	localparam int MAX_DIM    = 1024;

	typedef enum logic [1:0] {
		REG_WIDTH  = 2'd0,
		REG_HEIGHT = 2'd1,
		REG_RADIUS = 2'd2
	} reg_idx_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_MOD,
		ST_SHIFT,
		ST_LOAD,
		ST_STORE,
		ST_COUNT,
		ST_SCAN,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic [7:0] red_in;
		logic [7:0] green_in;
		logic [7:0] blue_in;
		logic       frame_start;
	} in_item_t;

	typedef struct packed {
		logic [7:0]       red_median;
		logic [7:0]       green_median;
		logic [7:0]       blue_median;
		logic [COL_W-1:0] out_column;
		logic [ROW_W-1:0] out_row;
	} out_item_t;

	typedef struct packed {
		logic              shift;
		logic              rotate;
		logic              load;
		logic [SIDE_W-1:0] row;
		logic              put;
	} win_ctrl_t;

	function automatic logic [HALF_W-1:0] half_count(input logic [RAD_W-1:0] r);
		logic [HALF_W-1:0] rr;
		rr = HALF_W'(r);
		return HALF_W'(2 * rr * (rr + HALF_W'(1)));
	endfunction

endpackage
`default_nettype wire

### design/rhmf_ram.sv
`timescale 1ns / 1ps
`default_nettype none
module rhmf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

### design/rhmf_mod.sv
`timescale 1ns / 1ps
`default_nettype none
module rhmf_mod (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       start,
	input  wire logic [rhmf_pkg::ROW_W-1:0] dividend,
	input  wire logic [rhmf_pkg::SIDE_W-1:0] divisor,
	output logic                            done,
	output logic [rhmf_pkg::SIDE_W-1:0]     rem
);
	import rhmf_pkg::*;

	localparam int ITER_W = $clog2(ROW_W + 1);

	logic [SIDE_W-1:0] rem_q;
	logic [ROW_W-1:0]  num_q;
	logic [ITER_W-1:0] iter_q;
	logic              busy_q;
	logic              done_q;
	logic [SIDE_W:0]   trial;

	assign trial = {rem_q, num_q[ROW_W-1]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			iter_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				iter_q <= ITER_W'(ROW_W);
			end else if (busy_q) begin
				iter_q <= iter_q - ITER_W'(1);
				if (iter_q == ITER_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			num_q <= dividend;
		end else if (busy_q) begin
			num_q <= num_q << 1;
			if (trial >= {1'b0, divisor}) begin
				rem_q <= SIDE_W'(trial - {1'b0, divisor});
			end else begin
				rem_q <= SIDE_W'(trial);
			end
		end
	end

	assign done = done_q;
	assign rem  = rem_q;

endmodule
`default_nettype wire

### design/rhmf_win.sv
`timescale 1ns / 1ps
`default_nettype none
module rhmf_win (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire rhmf_pkg::win_ctrl_t         ctrl,
	input  wire logic [rhmf_pkg::SIDE_W-1:0] side,
	input  wire logic [rhmf_pkg::PIX_W-1:0]  load_data,
	input  wire logic [rhmf_pkg::PIX_W-1:0]  pix,
	input  wire logic [rhmf_pkg::SIDE_W-1:0] rd_row,
	output logic      [rhmf_pkg::PIX_W-1:0]  rd_pix
);
	import rhmf_pkg::*;

	// [column][row], row 0 oldest
	logic [PIX_W-1:0] win_q [SIDE_MAX][SIDE_MAX];
	logic [SIDE_W-1:0] last;

	assign last = side - SIDE_W'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < SIDE_MAX; c++) begin
				for (int k = 0; k < SIDE_MAX; k++) begin
					win_q[c][k] <= '0;
				end
			end
		end else begin
			for (int c = 0; c < SIDE_MAX; c++) begin
				for (int k = 0; k < SIDE_MAX; k++) begin
					if ((ctrl.shift || ctrl.rotate) && SIDE_W'(c) < last) begin
						win_q[c][k] <= win_q[(c < SIDE_MAX - 1) ? c + 1 : c][k];
					end else if (ctrl.rotate && SIDE_W'(c) == last) begin
						win_q[c][k] <= win_q[0][k];
					end else if (ctrl.load && SIDE_W'(c) == last
							&& SIDE_W'(k) == ctrl.row) begin
						win_q[c][k] <= load_data;
					end else if (ctrl.put && SIDE_W'(c) == last
							&& SIDE_W'(k) == last) begin
						win_q[c][k] <= pix;
					end
				end
			end
		end
	end

	assign rd_pix = win_q[0][rd_row];

endmodule
`default_nettype wire

### design/rgb_histogram_median_filter.sv
`timescale 1ns / 1ps
`default_nettype none
// channel   handshake                  payload
// pixel     pixel_valid / pixel_ready  in_item_t
// result    result_valid / result_ready out_item_t
// apb       psel / penable / pready    paddr, pwdata, prdata
//
// a pixel waits for the row-slot remainder divider unless r = 0
// an output pixel adds (2r+1)^2 histogram updates, a scan of all 256 bins
// and an output step; updates read the window and read-modify-write the histogram rams
// after reset a histogram clearing pass over all 256 bins runs with pixel_ready low
// a result waits in the output register; a full register holds the next result
module rgb_histogram_median_filter (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        pixel_valid,
	output logic                             pixel_ready,
	input  wire rhmf_pkg::in_item_t          pixel,
	output logic                             result_valid,
	input  wire logic                        result_ready,
	output rhmf_pkg::out_item_t              result,
	input  wire logic                        psel,
	input  wire logic                        penable,
	input  wire logic                        pwrite,
	input  wire logic [rhmf_pkg::APB_AW-1:0] paddr,
	input  wire logic [rhmf_pkg::APB_DW-1:0] pwdata,
	output logic      [rhmf_pkg::APB_DW-1:0] prdata,
	output logic                             pready
);
	import rhmf_pkg::*;

	localparam int DIM_W = CFG_W;

	state_t state_q, state_d;

	logic [CFG_W-1:0] width_q, height_q;
	logic [RAD_W-1:0] radius_q;
	reg_idx_t         reg_idx;
	logic             cfg_wr;

	logic [COL_W-1:0] col_q, x_q;
	logic [ROW_W-1:0] row_q, y_q;
	logic [PIX_W-1:0] pix_q;
	logic             emit_q;
	logic [SIDE_W-1:0] slot0_q, slot_q, k_q, c_q;
	logic             phase_q;
	logic [BIN_W:0]   bin_q;
	logic [BIN_W-1:0] haddr_q [3];
	logic [CNT_W-1:0] acc_q [3];
	logic [7:0]       med_q [3];
	logic [2:0]       found_q;
	logic             ovalid_q;
	out_item_t        result_q;

	logic [DIM_W-1:0] w_eff, h_eff;
	logic [SIDE_W-1:0] side, rows;
	logic [HALF_W-1:0] half;
	logic             accept;
	logic [DIM_W-1:0] cc0, rc0, cc1, rc1, rc2, nx, ny;
	logic [COL_W-1:0] x_new;
	logic [ROW_W-1:0] y_new;

	logic             mod_done;
	logic [SIDE_W-1:0] mod_rem;

	win_ctrl_t        wctrl;
	logic [PIX_W-1:0] win_pix;

	logic             ls_we;
	logic [LS_AW-1:0] ls_waddr, ls_raddr;
	logic [PIX_W-1:0] ls_rdata;

	logic             h_we;
	logic [BIN_W-1:0] h_waddr;
	logic [BIN_W-1:0] h_raddr [3];
	logic [CNT_W-1:0] h_wdata [3];
	logic [CNT_W-1:0] h_rdata [3];

	logic             out_load;

	// configuration
	assign pready  = 1'b1;
	assign reg_idx = reg_idx_t'(paddr[3:2]);
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= CFG_W'(640);
			height_q <= CFG_W'(480);
			radius_q <= RAD_W'(1);
		end else if (cfg_wr) begin
			case (reg_idx)
				REG_WIDTH:  width_q  <= pwdata[CFG_W-1:0];
				REG_HEIGHT: height_q <= pwdata[CFG_W-1:0];
				REG_RADIUS: radius_q <= pwdata[RAD_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_WIDTH:  prdata = APB_DW'(width_q);
			REG_HEIGHT: prdata = APB_DW'(height_q);
			REG_RADIUS: prdata = APB_DW'(radius_q);
			default:    prdata = '0;
		endcase
	end

	assign w_eff = (width_q == '0) ? DIM_W'(1)
		: (width_q > DIM_W'(MAX_WIDTH)) ? DIM_W'(MAX_WIDTH)
		: (width_q > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : width_q;
	assign h_eff = (height_q == '0) ? DIM_W'(1)
		: (height_q > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : height_q;
	assign rows = {radius_q, 1'b0};
	assign side = rows + SIDE_W'(1);
	assign half = half_count(radius_q);

	// position of the arriving pixel and of the next one
	assign accept = pixel_valid && pixel_ready;

	always_comb begin
		cc0 = pixel.frame_start ? '0 : DIM_W'(col_q);
		rc0 = pixel.frame_start ? '0 : DIM_W'(row_q);
		if (cc0 >= w_eff) begin
			cc1 = '0;
			rc1 = rc0 + DIM_W'(1);
		end else begin
			cc1 = cc0;
			rc1 = rc0;
		end
		rc2   = (rc1 >= h_eff) ? '0 : rc1;
		x_new = cc1[COL_W-1:0];
		y_new = rc2[ROW_W-1:0];
		nx    = DIM_W'(x_new) + DIM_W'(1);
		ny    = DIM_W'(y_new);
		if (nx >= w_eff) begin
			nx = '0;
			ny = DIM_W'(y_new) + DIM_W'(1);
			if (ny >= h_eff) begin
				ny = '0;
			end
		end
	end

	rhmf_mod u_mod (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (accept && radius_q != '0),
		.dividend (y_new),
		.divisor  (rows),
		.done     (mod_done),
		.rem      (mod_rem)
	);

	rhmf_win u_win (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (wctrl),
		.side      (side),
		.load_data (ls_rdata),
		.pix       (pix_q),
		.rd_row    (k_q),
		.rd_pix    (win_pix)
	);

	assign ls_raddr = LS_AW'(slot_q) * LS_AW'(MAX_WIDTH) + LS_AW'(x_q);
	assign ls_waddr = LS_AW'(slot0_q) * LS_AW'(MAX_WIDTH) + LS_AW'(x_q);

	rhmf_ram #(
		.WIDTH (PIX_W),
		.DEPTH (LS_DEPTH)
	) u_line_store (
		.clk   (clk),
		.we    (ls_we),
		.waddr (ls_waddr),
		.wdata (pix_q),
		.raddr (ls_raddr),
		.rdata (ls_rdata)
	);

	for (genvar i = 0; i < 3; i++) begin : g_hist
		assign h_raddr[i] = (state_q == ST_COUNT) ? win_pix[8*i +: 8] : bin_q[BIN_W-1:0];
		assign h_wdata[i] = (state_q == ST_COUNT) ? h_rdata[i] + CNT_W'(1) : '0;
		rhmf_ram #(
			.WIDTH (CNT_W),
			.DEPTH (BINS)
		) u_hist (
			.clk   (clk),
			.we    (h_we),
			.waddr ((state_q == ST_COUNT) ? haddr_q[i] : h_waddr),
			.wdata (h_wdata[i]),
			.raddr (h_raddr[i]),
			.rdata (h_rdata[i])
		);
	end

	// sequencer
	always_comb begin
		state_d     = state_q;
		pixel_ready = 1'b0;
		wctrl       = '0;
		wctrl.row   = k_q - SIDE_W'(1);
		ls_we       = 1'b0;
		h_we        = 1'b0;
		h_waddr     = bin_q[BIN_W-1:0];
		out_load    = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				h_we = 1'b1;
				if (bin_q[BIN_W-1:0] == BIN_W'(BINS - 1)) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				pixel_ready = 1'b1;
				if (pixel_valid) begin
					state_d = (radius_q != '0) ? ST_MOD : ST_SHIFT;
				end
			end
			ST_MOD: begin
				if (mod_done) begin
					state_d = ST_SHIFT;
				end
			end
			ST_SHIFT: begin
				wctrl.shift = 1'b1;
				state_d     = (rows != '0) ? ST_LOAD : ST_STORE;
			end
			ST_LOAD: begin
				wctrl.load = (k_q != '0);
				if (k_q == rows) begin
					state_d = ST_STORE;
				end
			end
			ST_STORE: begin
				ls_we     = (rows != '0);
				wctrl.put = 1'b1;
				state_d   = emit_q ? ST_COUNT : ST_IDLE;
			end
			ST_COUNT: begin
				h_we = phase_q;
				if (phase_q && k_q == side - SIDE_W'(1)) begin
					wctrl.rotate = 1'b1;
					if (c_q == side - SIDE_W'(1)) begin
						state_d = ST_SCAN;
					end
				end
			end
			ST_SCAN: begin
				h_we    = (bin_q != '0);
				h_waddr = BIN_W'(bin_q - (BIN_W + 1)'(1));
				if (bin_q == (BIN_W + 1)'(BINS)) begin
					state_d = ST_OUT;
				end
			end
			ST_OUT: begin
				if (!ovalid_q || result_ready) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_CLEAR;
			col_q    <= '0;
			row_q    <= '0;
			bin_q    <= '0;
			k_q      <= '0;
			c_q      <= '0;
			phase_q  <= 1'b0;
			ovalid_q <= 1'b0;
			emit_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				col_q   <= nx[COL_W-1:0];
				row_q   <= ny[ROW_W-1:0];
				emit_q  <= (DIM_W'(x_new) >= DIM_W'(rows)) && (DIM_W'(y_new) >= DIM_W'(rows));
				k_q     <= '0;
			end
			case (state_q)
				ST_CLEAR: bin_q <= bin_q + (BIN_W + 1)'(1);
				ST_LOAD:  k_q <= k_q + SIDE_W'(1);
				ST_STORE: begin
					k_q     <= '0;
					c_q     <= '0;
					phase_q <= 1'b0;
				end
				ST_COUNT: begin
					phase_q <= !phase_q;
					if (phase_q) begin
						if (k_q == side - SIDE_W'(1)) begin
							k_q <= '0;
							c_q <= c_q + SIDE_W'(1);
						end else begin
							k_q <= k_q + SIDE_W'(1);
						end
					end
					bin_q <= '0;
				end
				ST_SCAN:  bin_q <= bin_q + (BIN_W + 1)'(1);
				default: ;
			endcase
			if (out_load) begin
				ovalid_q <= 1'b1;
			end else if (result_ready) begin
				ovalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			x_q   <= x_new;
			y_q   <= y_new;
			pix_q <= {pixel.blue_in, pixel.green_in, pixel.red_in};
		end
		if (state_q == ST_MOD && mod_done) begin
			slot0_q <= mod_rem;
			slot_q  <= mod_rem;
		end else if (state_q == ST_LOAD) begin
			slot_q <= (slot_q == rows - SIDE_W'(1)) ? '0 : slot_q + SIDE_W'(1);
		end
		for (int i = 0; i < 3; i++) begin
			if (state_q == ST_COUNT) begin
				haddr_q[i] <= win_pix[8*i +: 8];
				acc_q[i]   <= '0;
				found_q[i] <= 1'b0;
			end else if (state_q == ST_SCAN && bin_q != '0) begin
				acc_q[i] <= acc_q[i] + h_rdata[i];
				if (!found_q[i] && (acc_q[i] + h_rdata[i]) > CNT_W'(half)) begin
					found_q[i] <= 1'b1;
					med_q[i]   <= BIN_W'(bin_q - (BIN_W + 1)'(1));
				end
			end
		end
		if (out_load) begin
			result_q.red_median   <= med_q[0];
			result_q.green_median <= med_q[1];
			result_q.blue_median  <= med_q[2];
			result_q.out_column   <= x_q - COL_W'(radius_q);
			result_q.out_row      <= y_q - ROW_W'(radius_q);
		end
	end

	assign result_valid = ovalid_q;
	assign result       = result_q;

	a_out_from_seq: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(state_q == ST_OUT))
		else $error("result raised outside output step");

	a_count_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_COUNT |-> (k_q < side) && (c_q < side))
		else $error("histogram walk left the window");

	a_mod_done: assert property (@(posedge clk) disable iff (!arst_n)
		mod_done |-> state_q == ST_MOD)
		else $error("remainder finished outside its wait");

	a_scan_end: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN && bin_q == (BIN_W + 1)'(BINS)) |=> state_q == ST_OUT)
		else $error("scan did not hand over");

endmodule
`default_nettype wire
